[hdl/nnis_pkg.sv]
// nnis_pkg: shared constants, codes and types of the nearest-neighbour image scaler
// no dependencies; imported by every module of the scaler but nnis_ram

package nnis_pkg;

  // frame store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int PIXEL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = 2 * COORD_W;

  // divider pipeline: quotient bits resolved per stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = COORD_W / DIV_STEPS;

  // edges from the accepting edge to the edge that samples the result strobe
  localparam int RESULT_LAT = DIV_STAGES + 3;

  // size register limits
  localparam logic [DIM_W-1:0] DIM_MIN = 9'd1;
  localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
  } scale_cfg_t;

  // per-beat sideband that travels alongside the divider
  typedef struct packed {
    logic               rd;
    logic               err;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [PIXEL_W-1:0] pixel;
  } item_side_t;

endpackage

[hdl/nnis_ram.sv]
// nnis_ram: generic single-port ram with registered read data
// depends on nothing; width and depth set by parameters

module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/nnis_front.sv]
// nnis_front: first stage, range checks and coordinate-by-size products
// depends on nnis_pkg

module nnis_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          cmd_i,
  input  logic [nnis_pkg::COORD_W-1:0]  pos_x_i,
  input  logic [nnis_pkg::COORD_W-1:0]  pos_y_i,
  input  logic [nnis_pkg::PIXEL_W-1:0]  pixel_in_i,
  input  nnis_pkg::scale_cfg_t          cfg_i,
  output logic                          valid_o,
  output nnis_pkg::item_side_t          side_o,
  output logic [nnis_pkg::NUM_W-1:0]    num_x_o,
  output logic [nnis_pkg::NUM_W-1:0]    num_y_o
);
  import nnis_pkg::*;

  localparam int PROD_W = COORD_W + DIM_W;

  logic [DIM_W-1:0]  eff_w;
  logic [DIM_W-1:0]  eff_h;
  logic              rd;
  logic              err;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;

  logic              valid_q;
  item_side_t        side_d;
  item_side_t        side_q;
  logic [NUM_W-1:0]  num_x_q;
  logic [NUM_W-1:0]  num_y_q;

  // effective source size, limited by the store
  always_comb begin
    if (32'(cfg_i.src_width) > 32'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = cfg_i.src_width;
    end
    if (32'(cfg_i.src_height) > 32'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = cfg_i.src_height;
    end
  end

  // reads check the destination size, writes the source size
  assign rd = (cmd_i == CMD_READ);

  always_comb begin
    if (rd) begin
      err = (DIM_W'(pos_x_i) >= cfg_i.dst_width) || (DIM_W'(pos_y_i) >= cfg_i.dst_height);
    end else begin
      err = (DIM_W'(pos_x_i) >= eff_w) || (DIM_W'(pos_y_i) >= eff_h);
    end
  end

  // numerators of the scaled coordinate, always below 2^NUM_W
  assign prod_x = PROD_W'(pos_x_i) * PROD_W'(eff_w);
  assign prod_y = PROD_W'(pos_y_i) * PROD_W'(eff_h);

  always_comb begin
    side_d.rd    = rd;
    side_d.err   = err;
    side_d.pos_x = pos_x_i;
    side_d.pos_y = pos_y_i;
    side_d.pixel = pixel_in_i;
  end

  // beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side_q  <= side_d;
    num_x_q <= prod_x[NUM_W-1:0];
    num_y_q <= prod_y[NUM_W-1:0];
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;

endmodule

[hdl/nnis_div.sv]
// nnis_div: pipelined restoring divider, a few quotient bits per stage
// depends on nnis_pkg; the quotient is known to fit in COORD_W bits

module nnis_div (
  input  logic                         clk_i,
  input  logic [nnis_pkg::NUM_W-1:0]   num_i,
  input  logic [nnis_pkg::DIM_W-1:0]   divisor_i,
  output logic [nnis_pkg::COORD_W-1:0] quot_o
);
  import nnis_pkg::*;

  localparam int REM_W = DIM_W;
  localparam int TRY_W = DIM_W + 1;

  logic [REM_W-1:0]   rem_in [DIV_STAGES];
  logic [COORD_W-1:0] lo_in  [DIV_STAGES];
  logic [COORD_W-1:0] quo_in [DIV_STAGES];
  logic [REM_W-1:0]   rem_d  [DIV_STAGES];
  logic [COORD_W-1:0] lo_d   [DIV_STAGES];
  logic [COORD_W-1:0] quo_d  [DIV_STAGES];
  logic [REM_W-1:0]   rem_q  [DIV_STAGES];
  logic [COORD_W-1:0] lo_q   [DIV_STAGES];
  logic [COORD_W-1:0] quo_q  [DIV_STAGES];

  // stage inputs: upper numerator half seeds the remainder, it is below the divisor
  always_comb begin
    rem_in[0] = REM_W'(num_i[NUM_W-1:COORD_W]);
    lo_in[0]  = num_i[COORD_W-1:0];
    quo_in[0] = '0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s] = rem_q[s-1];
      lo_in[s]  = lo_q[s-1];
      quo_in[s] = quo_q[s-1];
    end
  end

  // shift in one numerator bit, compare, subtract; DIV_STEPS times per stage
  always_comb begin : div_steps
    logic [TRY_W-1:0] trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_d[s] = rem_in[s];
      lo_d[s]  = lo_in[s];
      quo_d[s] = quo_in[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial    = {rem_d[s], lo_d[s][COORD_W-1]};
        lo_d[s]  = {lo_d[s][COORD_W-2:0], 1'b0};
        if (trial >= TRY_W'(divisor_i)) begin
          trial    = trial - TRY_W'(divisor_i);
          quo_d[s] = {quo_d[s][COORD_W-2:0], 1'b1};
        end else begin
          quo_d[s] = {quo_d[s][COORD_W-2:0], 1'b0};
        end
        rem_d[s] = trial[REM_W-1:0];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s] <= rem_d[s];
      lo_q[s]  <= lo_d[s];
      quo_q[s] <= quo_d[s];
    end
  end

  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

[hdl/nearest_neighbor_image_scaler.sv]
// nearest_neighbor_image_scaler: top level, size registers, sideband pipe, frame store
// depends on nnis_pkg, nnis_front, nnis_div and nnis_ram
//
// usage
//   input beats are taken on every rising edge with start high; busy stays low,
//   so a beat may be offered every cycle. cmd_i = write stores pixel_in_i at
//   (pos_x_i, pos_y_i) of the source image and gives no result unless the
//   coordinate lies outside the source size. cmd_i = read maps the destination
//   coordinate to source (x*src_width/dst_width, y*src_height/dst_height),
//   floored, and returns that stored word on pixel_out_o.
//   out-of-range coordinates give one result with range_error_o high and zero data.
//   results are shown for one cycle with result_valid_o high, in accept order.
//   throughput is one beat per clock; latency is set by the input stage, the
//   four-stage divider (two quotient bits per stage), the frame store access and
//   the output register. writes reach the store in the same stage as reads, so
//   beat order is kept. size registers are written over the cfg channel (ready
//   always high) by the user only while no beat is in flight (the block does not
//   enforce it); reset sets all four sizes to 256 and empties the pipe. the frame
//   store is not cleared: read only what has been written. there is no
//   back-pressure from the receiver.

module nearest_neighbor_image_scaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [nnis_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [nnis_pkg::COORD_W-1:0]   pos_y_i,
  input  logic [nnis_pkg::PIXEL_W-1:0]   pixel_in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnis_pkg::DIM_W-1:0]     cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [nnis_pkg::PIXEL_W-1:0]   pixel_out_o,
  output logic                           range_error_o
);
  import nnis_pkg::*;

  scale_cfg_t         cfg_q;
  logic               in_acc;

  logic               front_valid;
  item_side_t         front_side;
  logic [NUM_W-1:0]   num_x;
  logic [NUM_W-1:0]   num_y;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;

  logic [DIV_STAGES-1:0] vld_q;
  item_side_t            side_q [DIV_STAGES];
  item_side_t            tail;
  logic                  tail_vld;

  logic [COORD_W-1:0] mem_x;
  logic [COORD_W-1:0] mem_y;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [PIXEL_W-1:0] ram_rdata;

  logic               mem_vld_q;
  logic               mem_rd_q;
  logic               mem_err_q;

  logic               res_vld_q;
  logic [PIXEL_W-1:0] pixel_q;
  logic               err_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_MIN) begin
      return DIM_MIN;
    end else if (v > DIM_MAX) begin
      return DIM_MAX;
    end
    return v;
  endfunction

  // handshakes
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = start && !busy;

  // size registers, saturated on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= DIM_MAX;
      cfg_q.src_height <= DIM_MAX;
      cfg_q.dst_width  <= DIM_MAX;
      cfg_q.dst_height <= DIM_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:  cfg_q.src_width  <= clamp_dim(cfg_wdata_i);
        REG_SRC_HEIGHT: cfg_q.src_height <= clamp_dim(cfg_wdata_i);
        REG_DST_WIDTH:  cfg_q.dst_width  <= clamp_dim(cfg_wdata_i);
        REG_DST_HEIGHT: cfg_q.dst_height <= clamp_dim(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // range checks and products
  nnis_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_acc),
    .cmd_i      (cmd_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_in_i (pixel_in_i),
    .cfg_i      (cfg_q),
    .valid_o    (front_valid),
    .side_o     (front_side),
    .num_x_o    (num_x),
    .num_y_o    (num_y)
  );

  // one divider per axis
  nnis_div u_div_x (
    .clk_i     (clk_i),
    .num_i     (num_x),
    .divisor_i (cfg_q.dst_width),
    .quot_o    (src_x)
  );

  nnis_div u_div_y (
    .clk_i     (clk_i),
    .num_i     (num_y),
    .divisor_i (cfg_q.dst_height),
    .quot_o    (src_y)
  );

  // sideband pipe, same depth as the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= front_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= front_side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  assign tail     = side_q[DIV_STAGES-1];
  assign tail_vld = vld_q[DIV_STAGES-1];

  // store access: reads use the scaled coordinate, writes their own
  assign mem_x    = tail.rd ? src_x : tail.pos_x;
  assign mem_y    = tail.rd ? src_y : tail.pos_y;
  assign mem_addr = ADDR_W'(mem_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(mem_x);
  assign mem_we   = tail_vld && !tail.rd && !tail.err;

  nnis_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (tail.pixel),
    .rdata_o (ram_rdata)
  );

  // stage alongside the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= 1'b0;
    end else begin
      mem_vld_q <= tail_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q  <= tail.rd;
    mem_err_q <= tail.err;
  end

  // output register: reads and errored beats give a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= mem_vld_q && (mem_rd_q || mem_err_q);
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= mem_err_q ? '0 : ram_rdata;
    err_q   <= mem_err_q;
  end

  assign result_valid_o = res_vld_q;
  assign pixel_out_o    = pixel_q;
  assign range_error_o  = err_q;

endmodule

[hdl/nnis_checker.sv]
// nnis_checker: port-level assertions on the scaler, bound to the top level
// depends on nnis_pkg and nearest_neighbor_image_scaler

module nnis_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         cmd_i,
  input logic                         result_valid_o,
  input logic [nnis_pkg::PIXEL_W-1:0] pixel_out_o,
  input logic                         range_error_o
);
  import nnis_pkg::*;

  // every accepted read is answered after the fixed latency
  a_read_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_READ) |-> ##RESULT_LAT result_valid_o)
    else $error("accepted read not answered");

  // no result without a beat accepted at the matching edge
  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, RESULT_LAT))
    else $error("result without an accepted beat");

  // a clean result always belongs to a read
  a_clean_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !range_error_o |-> $past(cmd_i, RESULT_LAT) == CMD_READ)
    else $error("error-free result from a write beat");

  // errored results carry zero data
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && range_error_o |-> pixel_out_o == '0)
    else $error("range error with non-zero pixel");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (.*);

[tb/sv/tb.sv]
// tb: self-checking bench for nearest_neighbor_image_scaler: corner beats, range errors,
// size register saturation, then random scaling traffic under several sender gap rates
// depends on nnis_pkg and the nearest_neighbor_image_scaler rtl

module tb;
  import nnis_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
  localparam int                   DRAIN_LIMIT   = 20 * RESULT_LAT + 200;
  localparam int                   SEGMENT_BEATS = 50;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               err;
  } scaled_pixel_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 cmd_i;
  logic [COORD_W-1:0]   pos_x_i;
  logic [COORD_W-1:0]   pos_y_i;
  logic [PIXEL_W-1:0]   pixel_in_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_wdata_i;
  logic                 result_valid_o;
  logic [PIXEL_W-1:0]   pixel_out_o;
  logic                 range_error_o;

  // model of the size registers and of the written part of the frame store
  scale_cfg_t           size_model = '{DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX};
  logic [PIXEL_W-1:0]   src_image [int unsigned];
  scaled_pixel_t        pending_pixels [$];
  int                   errors     = 0;
  int                   gap_pct    = 0;
  int                   seg_count  = 0;
  int                   beat_count = 0;

  nearest_neighbor_image_scaler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pixel_in_i     (pixel_in_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .pixel_out_o    (pixel_out_o),
    .range_error_o  (range_error_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // effective source sizes, bounded by the store
  function automatic int unsigned src_w();
    return (size_model.src_width > MAX_WIDTH) ? MAX_WIDTH : size_model.src_width;
  endfunction

  function automatic int unsigned src_h();
    return (size_model.src_height > MAX_HEIGHT) ? MAX_HEIGHT : size_model.src_height;
  endfunction

  // store address of the source pixel a destination coordinate lands on, floored exactly
  function automatic int unsigned src_addr(input logic [COORD_W-1:0] px,
                                           input logic [COORD_W-1:0] py);
    int unsigned sx, sy;
    sx = (px * src_w()) / size_model.dst_width;
    sy = (py * src_h()) / size_model.dst_height;
    return sy * MAX_WIDTH + sx;
  endfunction

  // a size register write saturates to 1..256
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  // scaled pixel for one accepted beat; returns 1 when the beat gives a result
  function automatic bit scale_pixel(input cmd_e cmd, input logic [COORD_W-1:0] px,
                                     input logic [COORD_W-1:0] py,
                                     input logic [PIXEL_W-1:0] pix,
                                     output scaled_pixel_t res);
    int unsigned addr;
    res.pixel = '0;
    res.err   = 1'b1;
    if (cmd == CMD_WRITE) begin
      if (px >= src_w() || py >= src_h()) return 1'b1;
      src_image[py * MAX_WIDTH + px] = pix;
      return 1'b0;
    end
    if (px >= size_model.dst_width || py >= size_model.dst_height) return 1'b1;
    addr      = src_addr(px, py);
    res.err   = 1'b0;
    res.pixel = src_image.exists(addr) ? src_image[addr] : '0;
    return 1'b1;
  endfunction

  // send one input beat, with random idle cycles ahead of it
  task automatic send_beat(input cmd_e cmd, input logic [COORD_W-1:0] px,
                           input logic [COORD_W-1:0] py, input logic [PIXEL_W-1:0] pix);
    scaled_pixel_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start      <= 1'b1;
    cmd_i      <= cmd;
    pos_x_i    <= px;
    pos_y_i    <= py;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (busy);
    beat_count++;
    if (scale_pixel(cmd, px, py, pix, res)) pending_pixels.push_back(res);
  endtask

  // read a destination pixel; the source pixel it maps to is written first if still blank
  task automatic fetch_scaled(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    int unsigned addr;
    if (px < size_model.dst_width && py < size_model.dst_height) begin
      addr = src_addr(px, py);
      if (!src_image.exists(addr))
        send_beat(CMD_WRITE, COORD_W'(addr % MAX_WIDTH), COORD_W'(addr / MAX_WIDTH),
                  $urandom);
    end
    send_beat(CMD_READ, px, py, $urandom);
  endtask

  // stop sending and let the pipe empty, writes included
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected results never arrived, oldest pixel %h err %b",
               $time, pending_pixels.size(), pending_pixels[0].pixel, pending_pixels[0].err);
      errors++;
      pending_pixels.delete();
    end
    repeat (RESULT_LAT + 4) @(posedge clk_i);
  endtask

  // one size register write beat
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SRC_WIDTH:  size_model.src_width  = clamp_dim(val);
      REG_SRC_HEIGHT: size_model.src_height = clamp_dim(val);
      REG_DST_WIDTH:  size_model.dst_width  = clamp_dim(val);
      REG_DST_HEIGHT: size_model.dst_height = clamp_dim(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                           input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
    settle();
    set_reg(REG_SRC_WIDTH, sw);
    set_reg(REG_SRC_HEIGHT, sh);
    set_reg(REG_DST_WIDTH, dw);
    set_reg(REG_DST_HEIGHT, dh);
  endtask

  // corner pixels at the reset sizes, where scaling is the identity
  task automatic test_identity_corners();
    send_beat(CMD_WRITE, 8'd0, 8'd0, 32'h0000_0000);
    send_beat(CMD_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_beat(CMD_WRITE, 8'd255, 8'd0, 32'hAAAA_AAAA);
    send_beat(CMD_WRITE, 8'd0, 8'd255, 32'h5555_5555);
    fetch_scaled(8'd0, 8'd0);
    fetch_scaled(8'd255, 8'd255);
    fetch_scaled(8'd255, 8'd0);
    fetch_scaled(8'd0, 8'd255);
  endtask

  // coordinates past the source or destination edge, and some in range
  task automatic test_range_errors();
    set_sizes(9'd10, 9'd20, 9'd30, 9'd5);
    send_beat(CMD_WRITE, 8'd10, 8'd0, 32'h1234_5678);
    send_beat(CMD_WRITE, 8'd0, 8'd20, 32'h8765_4321);
    send_beat(CMD_WRITE, 8'd9, 8'd19, 32'hC0FF_EE00);
    send_beat(CMD_READ, 8'd30, 8'd0, 32'h0);
    send_beat(CMD_READ, 8'd0, 8'd5, 32'h0);
    send_beat(CMD_READ, 8'd255, 8'd255, 32'h0);
    fetch_scaled(8'd29, 8'd4);
    fetch_scaled(8'd0, 8'd0);
  endtask

  // zero and oversize register values saturate; unused indexes change nothing
  task automatic test_size_saturation();
    settle();
    set_reg(REG_SRC_WIDTH, 9'd0);
    set_reg(REG_SRC_HEIGHT, 9'd511);
    set_reg(REG_DST_WIDTH, 9'd300);
    set_reg(REG_DST_HEIGHT, 9'd257);
    for (int k = 0; k < 4; k++)
      set_reg(CFG_IDX_W'(REG_UNUSED_LO + k), (k % 2) ? 9'h1FF : 9'd5);
    fetch_scaled(8'd255, 8'd255);
    fetch_scaled(8'd255, 8'd0);
    fetch_scaled(8'd128, 8'd77);
    send_beat(CMD_WRITE, 8'd1, 8'd0, 32'hDEAD_BEEF);
  endtask

  // random traffic; sizes change every segment, extremes first
  task automatic test_random_scaling(input int beats, input int idle_pct);
    int choice;
    int kind;
    int first;
    gap_pct = idle_pct;
    first   = beat_count;
    for (int n = 0; beat_count - first < beats; n++) begin
      if (n % SEGMENT_BEATS == 0) begin
        choice = (seg_count < 4) ? seg_count : 4 + $urandom_range(1);
        seg_count++;
        case (choice)
          0: set_sizes(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
          1: set_sizes(DIM_MIN, DIM_MIN, DIM_MIN, DIM_MIN);
          2: set_sizes(DIM_MIN, 9'd2, DIM_MAX, DIM_MAX);
          3: set_sizes(DIM_MAX, DIM_MAX, 9'd3, 9'd2);
          4: set_sizes(DIM_W'($urandom_range(256, 1)), DIM_W'($urandom_range(256, 1)),
                       DIM_W'($urandom_range(256, 1)), DIM_W'($urandom_range(256, 1)));
          default: set_sizes(DIM_W'($urandom_range(511)), DIM_W'($urandom_range(511)),
                             DIM_W'($urandom_range(511)), DIM_W'($urandom_range(511)));
        endcase
      end
      kind = $urandom_range(99);
      if (kind < 55)
        fetch_scaled(COORD_W'($urandom_range(size_model.dst_width - 1)),
                     COORD_W'($urandom_range(size_model.dst_height - 1)));
      else if (kind < 75)
        send_beat(CMD_WRITE, COORD_W'($urandom_range(src_w() - 1)),
                  COORD_W'($urandom_range(src_h() - 1)), $urandom);
      else if (kind < 87)
        send_beat(CMD_WRITE, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                  $urandom);
      else
        fetch_scaled(COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)));
    end
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin : check_results
    scaled_pixel_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, got pixel %h err %b",
                 $time, pixel_out_o, range_error_o);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out_o !== want.pixel) begin
          $display("%0t: pixel_out mismatch, expected %h got %h",
                   $time, want.pixel, pixel_out_o);
          errors++;
        end
        if (range_error_o !== want.err) begin
          $display("%0t: range_error mismatch, expected %b got %b",
                   $time, want.err, range_error_o);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = CMD_WRITE;
    pos_x_i     = '0;
    pos_y_i     = '0;
    pixel_in_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SRC_WIDTH;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_identity_corners();
    test_range_errors();
    test_size_saturation();
    test_random_scaling(210, 34);
    test_random_scaling(210, 74);
    test_random_scaling(210, 0);
    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/nnis_pkg.sv
hdl/nnis_ram.sv
hdl/nnis_front.sv
hdl/nnis_div.sv
hdl/nearest_neighbor_image_scaler.sv
hdl/nnis_checker.sv
tb/sv/tb.sv
